[rtl/md5_pkg.sv]
// md5 engine package: types, constants and round tables
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7; 4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5; 4'd5: s = 5'd9; 4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4; 4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] g;
		unique case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage

[rtl/md5_ram.sv]
// generic single-port-write ram with registered read
module md5_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/md5_round.sv]
// one md5 round step on the working registers
module md5_round (
	input  logic [5:0]  idx,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] w,
	output logic [31:0] b_next
);
	logic [31:0] f;
	logic [31:0] t;
	logic [4:0]  s;

	always_comb begin
		unique case (idx[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		t = a + f + w + md5_pkg::round_k(idx);
		s = md5_pkg::round_s(idx);
		b_next = b + ((t << s) | (t >> (6'd32 - {1'b0, s})));
	end
endmodule

[rtl/md5_hash_engine.sv]
// md5 hash engine top level: block ram, round sequencer and digest output
//
// channel  valid      ready      payload
// in       in_valid   in_ready   cmd, data_byte
// out      out_valid  out_ready  digest_word, word_index, last
//
// an append byte is written straight into the block ram; the 64th byte of a block starts a compression
// of 64 rounds followed by an add, with one word read from the block ram per round
// finish writes the padding one byte a cycle, pausing while a compression runs, then the 8-byte length,
// runs one or two compressions, then emits four words
// reset restores the initial vector and a zero byte count; no clearing pass
// the output register stalls only the emit phase; input waits while busy
module md5_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last
);
	md5_pkg::state_t state_q, state_d;

	logic [60:0] count_q, count_d;
	logic [5:0]  ptr_q, ptr_d;
	logic [6:0]  rnd_q, rnd_d;
	logic        fin_q, fin_d;
	logic        lenrun_q, lenrun_d;
	logic [31:0] ha_q, hb_q, hc_q, hd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [1:0]  oidx_q;
	logic        ovalid_q;

	logic [3:0]  ram_we;
	logic [5:0]  ram_waddr;
	logic [7:0]  ram_wbyte;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] b_next;
	logic [63:0] bits;
	logic        start_round;
	logic        do_add;
	logic        accept;

	genvar gl;
	for (gl = 0; gl < 4; gl++) begin : g_lane
		md5_ram #(.Width(8), .Depth(16)) u_ram (
			.clk(clk),
			.we(ram_we[gl]),
			.waddr(ram_waddr[5:2]),
			.wdata(ram_wbyte),
			.raddr(ram_raddr),
			.rdata(ram_rdata[8*gl +: 8])
		);
	end

	md5_round u_round (
		.idx(rnd_q[5:0]),
		.a(a_q),
		.b(b_q),
		.c(c_q),
		.d(d_q),
		.w(ram_rdata),
		.b_next(b_next)
	);

	assign bits = {count_q, 3'b000};
	assign in_ready = (state_q == md5_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		rnd_d = rnd_q;
		fin_d = fin_q;
		lenrun_d = lenrun_q;
		ram_we = 4'b0000;
		ram_waddr = ptr_q;
		ram_wbyte = 8'h00;
		ram_raddr = md5_pkg::round_g(6'd0);
		start_round = 1'b0;
		do_add = 1'b0;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				if (accept) begin
					ram_waddr = count_q[5:0];
					ram_we[count_q[1:0]] = 1'b1;
					if (cmd == md5_pkg::CMD_APPEND) begin
						ram_wbyte = data_byte;
						count_d = count_q + 61'd1;
						if (count_q[5:0] == 6'd63) begin
							fin_d = 1'b0;
							start_round = 1'b1;
							state_d = md5_pkg::ST_ROUND;
						end
					end else begin
						ram_wbyte = md5_pkg::PAD_BYTE;
						fin_d = 1'b1;
						lenrun_d = 1'b0;
						ptr_d = count_q[5:0] + 6'd1;
						if (count_q[5:0] == 6'd63) begin
							start_round = 1'b1;
							state_d = md5_pkg::ST_ROUND;
						end else if (count_q[5:0] == 6'd55) begin
							state_d = md5_pkg::ST_LEN;
						end else begin
							state_d = md5_pkg::ST_PAD;
						end
					end
				end
			end
			md5_pkg::ST_PAD: begin
				ram_we[ptr_q[1:0]] = 1'b1;
				ram_wbyte = 8'h00;
				ptr_d = ptr_q + 6'd1;
				if (!lenrun_q && ptr_q == 6'd55 && count_q[5:0] < 6'd56) begin
					state_d = md5_pkg::ST_LEN;
				end else if (ptr_q == 6'd63) begin
					start_round = 1'b1;
					state_d = md5_pkg::ST_ROUND;
				end else if (lenrun_q && ptr_q == 6'd55) begin
					state_d = md5_pkg::ST_LEN;
				end
			end
			md5_pkg::ST_LEN: begin
				ram_we[ptr_q[1:0]] = 1'b1;
				ram_wbyte = bits[8*ptr_q[2:0] +: 8];
				ptr_d = ptr_q + 6'd1;
				if (ptr_q == 6'd63) begin
					lenrun_d = 1'b1;
					start_round = 1'b1;
					state_d = md5_pkg::ST_ROUND;
				end
			end
			md5_pkg::ST_ROUND: begin
				ram_raddr = md5_pkg::round_g(rnd_q[5:0] + 6'd1);
				rnd_d = rnd_q + 7'd1;
				if (rnd_q == 7'd63) begin
					state_d = md5_pkg::ST_ADD;
				end
			end
			md5_pkg::ST_ADD: begin
				do_add = 1'b1;
				if (!fin_q) begin
					state_d = md5_pkg::ST_IDLE;
				end else if (lenrun_q) begin
					state_d = md5_pkg::ST_EMIT;
				end else begin
					lenrun_d = 1'b1;
					ptr_d = 6'd0;
					state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_EMIT: begin
				if (ovalid_q && out_ready && oidx_q == 2'd3) begin
					count_d = '0;
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
		if (start_round) begin
			rnd_d = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			lenrun_q <= 1'b0;
			ha_q <= md5_pkg::IV_A;
			hb_q <= md5_pkg::IV_B;
			hc_q <= md5_pkg::IV_C;
			hd_q <= md5_pkg::IV_D;
			oidx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q <= ptr_d;
			rnd_q <= rnd_d;
			fin_q <= fin_d;
			lenrun_q <= lenrun_d;
			if (do_add) begin
				ha_q <= ha_q + a_q;
				hb_q <= hb_q + b_q;
				hc_q <= hc_q + c_q;
				hd_q <= hd_q + d_q;
				if (fin_q && lenrun_q) begin
					ovalid_q <= 1'b1;
					oidx_q <= 2'd0;
				end
			end else if (ovalid_q && out_ready) begin
				oidx_q <= oidx_q + 2'd1;
				if (oidx_q == 2'd3) begin
					ovalid_q <= 1'b0;
					ha_q <= md5_pkg::IV_A;
					hb_q <= md5_pkg::IV_B;
					hc_q <= md5_pkg::IV_C;
					hd_q <= md5_pkg::IV_D;
				end
			end
		end
	end

	// working registers load at round start, step once per round
	always_ff @(posedge clk) begin
		if (start_round) begin
			a_q <= ha_q;
			b_q <= hb_q;
			c_q <= hc_q;
			d_q <= hd_q;
		end else if (state_q == md5_pkg::ST_ROUND) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_next;
		end
	end

	assign out_valid = ovalid_q;
	assign word_index = oidx_q;
	assign last = (oidx_q == 2'd3);

	always_comb begin
		unique case (oidx_q)
			2'd0: digest_word = ha_q;
			2'd1: digest_word = hb_q;
			2'd2: digest_word = hc_q;
			default: digest_word = hd_q;
		endcase
	end
endmodule
